FILE: hdl/frnl_pkg.sv
// Package for the fixed-radius neighbor list: field widths, reset values,
// code enums and the structs passed between the front, back and queues.
// No dependencies.
`timescale 1ns / 1ps

package frnl_pkg;

   localparam int INDEX_WIDTH         = 6;
   localparam int COUNT_WIDTH         = 7;
   localparam int CUTOFF_WIDTH        = 16;
   localparam int CSR_DATA_WIDTH      = 16;
   localparam int CSR_INDEX_WIDTH     = 1;
   localparam int MAX_POINTS_DEFAULT  = 64;
   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int RESET_POINT_COUNT   = 64;
   localparam int RESET_CUTOFF        = 6400;
   localparam int CMD_DEPTH           = 2;
   localparam int RSP_DEPTH           = 8;
   localparam int RSP_SLACK           = 5;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_POINT_COUNT = 1'b0,
      CSR_CUTOFF_DIST = 1'b1
   } csr_index_type;

   typedef enum logic {
      MODE_LOAD  = 1'b0,
      MODE_QUERY = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      CMD_LOAD  = 2'd0,
      CMD_QUERY = 2'd1,
      CMD_EMPTY = 2'd2
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_POINT = 2'd1,
      ST_SCAN  = 2'd2,
      ST_DRAIN = 2'd3
   } back_state_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [INDEX_WIDTH-1:0] index;
      logic [COUNT_WIDTH-1:0] limit;
   } cmd_type;

   typedef struct packed {
      logic [INDEX_WIDTH-1:0] neighbor_index;
      logic                   found;
      logic                   last;
   } rsp_type;

endpackage

FILE: hdl/frnl_fifo.sv
// Small synchronous queue with occupancy count, used for the command queue
// and the result queue. Depends on nothing.
`timescale 1ns / 1ps

module frnl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   output logic                       full,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] count
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push_ok, pop_ok;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign count    = count_ff;
   assign pop_data = mem_ff[rd_ptr_ff];
   assign push_ok  = push && !full;
   assign pop_ok   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push_ok, pop_ok})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hdl/frnl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module frnl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] write_address,
   input  logic [WIDTH-1:0]         write_data,
   input  logic [$clog2(DEPTH)-1:0] read_address,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   assign read_data = read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem_ff[write_address] <= write_data;
      end
      read_data_ff <= mem_ff[read_address];
   end

endmodule

FILE: hdl/frnl_front.sv
// Front end: takes request transactions, classifies them and queues commands
// for the back end. Depends on frnl_pkg and frnl_fifo.
`timescale 1ns / 1ps

module frnl_front
   import frnl_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_mode,
   input  logic [INDEX_WIDTH-1:0] req_point_index,
   input  logic [COORD_WIDTH-1:0] req_x_coord,
   input  logic [COORD_WIDTH-1:0] req_y_coord,
   input  logic [COUNT_WIDTH-1:0] point_count,
   input  logic                   cmd_pop,
   output logic                   cmd_empty,
   output cmd_type                cmd_head,
   output logic [COORD_WIDTH-1:0] cmd_x,
   output logic [COORD_WIDTH-1:0] cmd_y
);

   localparam int CMD_W = $bits(cmd_type) + 2 * COORD_WIDTH;

   cmd_type                cmd_new;
   logic                   in_range;
   logic                   keep;
   logic [COUNT_WIDTH-1:0] limit;
   logic [CMD_W-1:0]       pop_word;

   always_comb begin
      in_range = ({1'b0, req_point_index} < COUNT_WIDTH'(MAX_POINTS));
      limit    = (point_count > COUNT_WIDTH'(MAX_POINTS)) ? COUNT_WIDTH'(MAX_POINTS)
                                                          : point_count;
      cmd_new.index = req_point_index;
      cmd_new.limit = limit;
      if (mode_type'(req_mode) == MODE_LOAD) begin
         cmd_new.kind = CMD_LOAD;
         keep         = in_range;
      end else begin
         cmd_new.kind = (in_range && (limit != '0)) ? CMD_QUERY : CMD_EMPTY;
         keep         = 1'b1;
      end
   end

   frnl_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push && keep),
      .push_data ({cmd_new, req_x_coord, req_y_coord}),
      .full      (req_full),
      .pop       (cmd_pop),
      .pop_data  (pop_word),
      .empty     (cmd_empty),
      .count     ()
   );

   assign {cmd_head, cmd_x, cmd_y} = pop_word;

endmodule

FILE: hdl/frnl_back.sv
// Back end: executes loads into the point store and scans the store for
// queries through a read, distance and square-sum pipeline.
// Depends on frnl_pkg and frnl_ram.
`timescale 1ns / 1ps

module frnl_back
   import frnl_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           cmd_empty,
   input  cmd_type                        cmd_head,
   input  logic [COORD_WIDTH-1:0]         cmd_x,
   input  logic [COORD_WIDTH-1:0]         cmd_y,
   output logic                           cmd_pop,
   input  logic [CUTOFF_WIDTH-1:0]        cutoff_dist,
   input  logic                           rsp_full,
   input  logic [$clog2(RSP_DEPTH+1)-1:0] rsp_count,
   output logic                           rsp_push,
   output rsp_type                        rsp_data
);

   localparam int IDX_W = $clog2(MAX_POINTS);
   localparam int CMP_W = (COORD_WIDTH > CUTOFF_WIDTH) ? COORD_WIDTH : CUTOFF_WIDTH;
   localparam int SQ_W  = 2 * CUTOFF_WIDTH;
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH+1);

   back_state_type state_ff, state_in;

   logic [COUNT_WIDTH-1:0]   j_ff, j_in;
   logic [COUNT_WIDTH-1:0]   limit_ff, limit_in;
   logic [INDEX_WIDTH-1:0]   qidx_ff, qidx_in;
   logic [COORD_WIDTH-1:0]   qx_ff, qx_in, qy_ff, qy_in;
   logic                     pend_valid_ff, pend_valid_in;
   logic [INDEX_WIDTH-1:0]   pend_idx_ff, pend_idx_in;
   logic [SQ_W-1:0]          cutoff_sq_ff;

   logic                     v1_ff, v1_in;
   logic [INDEX_WIDTH-1:0]   j1_ff, j1_in;
   logic                     v2_ff, ok2_ff, ok2_in;
   logic [INDEX_WIDTH-1:0]   j2_ff;
   logic [CUTOFF_WIDTH-1:0]  dx2_ff, dy2_ff;
   logic                     v3_ff, ok3_ff;
   logic [INDEX_WIDTH-1:0]   j3_ff;
   logic [SQ_W-1:0]          sqx3_ff, sqy3_ff;

   logic                     ram_we;
   logic [IDX_W-1:0]         ram_waddr, ram_raddr;
   logic [2*COORD_WIDTH-1:0] ram_rdata;
   logic [COORD_WIDTH-1:0]   px, py, dx, dy;
   logic [SQ_W:0]            dist_sq;
   logic                     hit, issue;

   frnl_ram #(
      .WIDTH (2 * COORD_WIDTH),
      .DEPTH (MAX_POINTS)
   ) u_store (
      .clock         (clock),
      .write_enable  (ram_we),
      .write_address (ram_waddr),
      .write_data    ({cmd_x, cmd_y}),
      .read_address  (ram_raddr),
      .read_data     (ram_rdata)
   );

   assign {px, py} = ram_rdata;

   always_comb begin
      dx     = (px >= qx_ff) ? px - qx_ff : qx_ff - px;
      dy     = (py >= qy_ff) ? py - qy_ff : qy_ff - py;
      ok2_in = v1_ff && (j1_ff != qidx_ff)
               && (CMP_W'(dx) <= CMP_W'(cutoff_dist))
               && (CMP_W'(dy) <= CMP_W'(cutoff_dist));
      dist_sq = {1'b0, sqx3_ff} + {1'b0, sqy3_ff};
      hit     = v3_ff && ok3_ff && (dist_sq <= {1'b0, cutoff_sq_ff});
   end

   always_comb begin
      state_in      = state_ff;
      j_in          = j_ff;
      limit_in      = limit_ff;
      qidx_in       = qidx_ff;
      qx_in         = qx_ff;
      qy_in         = qy_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      v1_in         = 1'b0;
      j1_in         = j_ff[INDEX_WIDTH-1:0];
      cmd_pop       = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = cmd_head.index[IDX_W-1:0];
      ram_raddr     = j_ff[IDX_W-1:0];
      rsp_push      = 1'b0;
      rsp_data      = '{neighbor_index: pend_idx_ff, found: 1'b1, last: 1'b0};
      issue         = 1'b0;

      if (hit) begin
         rsp_push      = pend_valid_ff;
         pend_valid_in = 1'b1;
         pend_idx_in   = j3_ff;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               unique case (cmd_head.kind)
                  CMD_LOAD: begin
                     ram_we = 1'b1;
                  end
                  CMD_QUERY: begin
                     ram_raddr = cmd_head.index[IDX_W-1:0];
                     qidx_in   = cmd_head.index;
                     limit_in  = cmd_head.limit;
                     j_in      = '0;
                     state_in  = ST_POINT;
                  end
                  CMD_EMPTY: begin
                     state_in = ST_DRAIN;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_POINT: begin
            qx_in    = px;
            qy_in    = py;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            issue = (j_ff < limit_ff)
                    && (rsp_count <= RSP_CNT_W'(RSP_DEPTH - RSP_SLACK));
            if (issue) begin
               v1_in = 1'b1;
               j_in  = j_ff + 1'b1;
            end
            if (j_ff == limit_ff) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!v1_ff && !v2_ff && !v3_ff && !rsp_full) begin
               rsp_push      = 1'b1;
               rsp_data      = pend_valid_ff
                  ? rsp_type'{neighbor_index: pend_idx_ff, found: 1'b1, last: 1'b1}
                  : rsp_type'{neighbor_index: '0, found: 1'b0, last: 1'b1};
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_valid_ff <= 1'b0;
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         v3_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_valid_ff <= pend_valid_in;
         v1_ff         <= v1_in;
         v2_ff         <= v1_ff;
         v3_ff         <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      j_ff         <= j_in;
      limit_ff     <= limit_in;
      qidx_ff      <= qidx_in;
      qx_ff        <= qx_in;
      qy_ff        <= qy_in;
      pend_idx_ff  <= pend_idx_in;
      cutoff_sq_ff <= SQ_W'(cutoff_dist) * SQ_W'(cutoff_dist);
      j1_ff        <= j1_in;
      j2_ff        <= j1_ff;
      ok2_ff       <= ok2_in;
      dx2_ff       <= CUTOFF_WIDTH'(CMP_W'(dx));
      dy2_ff       <= CUTOFF_WIDTH'(CMP_W'(dy));
      j3_ff        <= j2_ff;
      ok3_ff       <= ok2_ff;
      sqx3_ff      <= SQ_W'(dx2_ff) * SQ_W'(dx2_ff);
      sqy3_ff      <= SQ_W'(dy2_ff) * SQ_W'(dy2_ff);
   end

endmodule

FILE: hdl/fixed_radius_neighbor_list.sv
// Top level of the fixed-radius neighbor list: configuration registers, front end,
// back end and result queue. Depends on frnl_pkg, frnl_fifo, frnl_front, frnl_back.
//
//   Channel   Handshake              Payload
//   req_      push / full            mode, point_index, x_coord, y_coord
//   rsp_      pop / empty            neighbor_index, found, last
//   csr_      write_enable           index, write_data
//
// A load is written into the point store in the same cycle that it leaves the command queue.
// A query first reads the query point, then makes one store read per stored point up to
// point_count (at most MAX_POINTS), and then drains a three-stage distance pipeline.
// The single read port of the point store paces the scan.
// Reset is synchronous and active high; the point store is not cleared.
// The scan pauses while the result queue is nearly full.
`timescale 1ns / 1ps

module fixed_radius_neighbor_list
   import frnl_pkg::*;
#(
   parameter int MAX_POINTS  = MAX_POINTS_DEFAULT,
   parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_push,
   output logic                       req_full,
   input  logic                       req_mode,
   input  logic [INDEX_WIDTH-1:0]     req_point_index,
   input  logic [COORD_WIDTH-1:0]     req_x_coord,
   input  logic [COORD_WIDTH-1:0]     req_y_coord,
   output logic                       rsp_empty,
   input  logic                       rsp_pop,
   output logic [INDEX_WIDTH-1:0]     rsp_neighbor_index,
   output logic                       rsp_found,
   output logic                       rsp_last,
   input  logic                       csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_write_data
);

   localparam int RSP_CNT_W = $clog2(RSP_DEPTH+1);

   logic [COUNT_WIDTH-1:0]  point_count_ff;
   logic [CUTOFF_WIDTH-1:0] cutoff_dist_ff;

   logic                    cmd_empty, cmd_pop;
   cmd_type                 cmd_head;
   logic [COORD_WIDTH-1:0]  cmd_x, cmd_y;
   logic                    rsp_push, rsp_full;
   logic [RSP_CNT_W-1:0]    rsp_count;
   rsp_type                 rsp_in, rsp_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         point_count_ff <= COUNT_WIDTH'(RESET_POINT_COUNT);
         cutoff_dist_ff <= CUTOFF_WIDTH'(RESET_CUTOFF);
      end else if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_POINT_COUNT: point_count_ff <= csr_write_data[COUNT_WIDTH-1:0];
            CSR_CUTOFF_DIST: cutoff_dist_ff <= csr_write_data[CUTOFF_WIDTH-1:0];
            default:         point_count_ff <= point_count_ff;
         endcase
      end
   end

   frnl_front #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_push        (req_push),
      .req_full        (req_full),
      .req_mode        (req_mode),
      .req_point_index (req_point_index),
      .req_x_coord     (req_x_coord),
      .req_y_coord     (req_y_coord),
      .point_count     (point_count_ff),
      .cmd_pop         (cmd_pop),
      .cmd_empty       (cmd_empty),
      .cmd_head        (cmd_head),
      .cmd_x           (cmd_x),
      .cmd_y           (cmd_y)
   );

   frnl_back #(
      .MAX_POINTS  (MAX_POINTS),
      .COORD_WIDTH (COORD_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_empty   (cmd_empty),
      .cmd_head    (cmd_head),
      .cmd_x       (cmd_x),
      .cmd_y       (cmd_y),
      .cmd_pop     (cmd_pop),
      .cutoff_dist (cutoff_dist_ff),
      .rsp_full    (rsp_full),
      .rsp_count   (rsp_count),
      .rsp_push    (rsp_push),
      .rsp_data    (rsp_in)
   );

   frnl_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_data (rsp_in),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_out),
      .empty     (rsp_empty),
      .count     (rsp_count)
   );

   assign rsp_neighbor_index = rsp_out.neighbor_index;
   assign rsp_found          = rsp_out.found;
   assign rsp_last           = rsp_out.last;

   a_no_rsp_overflow: assert property (@(posedge clock) disable iff (reset)
      !(rsp_push && rsp_full))
      else $error("result transaction pushed into a full result queue");

   a_miss_is_last: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_found |-> rsp_last)
      else $error("a result without a neighbor is not the last of its query");

   a_miss_index_zero: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_found |-> rsp_neighbor_index == '0)
      else $error("a result without a neighbor carries a nonzero index");

   a_cmd_pop_legal: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command taken from an empty command queue");

endmodule

FILE: tb/frnl_neighbor_checker.sv
// Checker for the fixed-radius neighbor list: watches the request, result and register
// channels, keeps its own copy of the point store and predicts every neighbor result.
// Depends on frnl_pkg.
`timescale 1ns / 1ps

module frnl_neighbor_checker
   import frnl_pkg::*;
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_push,
   input  logic                           req_full,
   input  logic                           req_mode,
   input  logic [INDEX_WIDTH-1:0]         req_point_index,
   input  logic [COORD_WIDTH_DEFAULT-1:0] req_x_coord,
   input  logic [COORD_WIDTH_DEFAULT-1:0] req_y_coord,
   input  logic                           rsp_empty,
   input  logic                           rsp_pop,
   input  logic [INDEX_WIDTH-1:0]         rsp_neighbor_index,
   input  logic                           rsp_found,
   input  logic                           rsp_last,
   input  logic                           csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]      csr_write_data,
   output int                             mismatch_count,
   output int                             outstanding,
   output int                             results_checked
);

   localparam int STORE_DEPTH = MAX_POINTS_DEFAULT;

   logic [COORD_WIDTH_DEFAULT-1:0] x_points [STORE_DEPTH];
   logic [COORD_WIDTH_DEFAULT-1:0] y_points [STORE_DEPTH];
   logic [COUNT_WIDTH-1:0]         point_count;
   logic [CUTOFF_WIDTH-1:0]        cutoff_dist;
   rsp_type                        neighbor_queue [$];

   function automatic void find_neighbors(input logic [INDEX_WIDTH-1:0] center);
      int                     span;
      int                     final_hit;
      longint unsigned        dx;
      longint unsigned        dy;
      longint unsigned        radius;
      bit [STORE_DEPTH-1:0]   hits;
      rsp_type                entry;
      span = (point_count > STORE_DEPTH) ? STORE_DEPTH : int'(point_count);
      radius = cutoff_dist;
      hits = '0;
      final_hit = -1;
      for (int j = 0; j < span; j++) begin
         if (j != center) begin
            dx = (x_points[center] >= x_points[j]) ? x_points[center] - x_points[j]
                                                   : x_points[j] - x_points[center];
            dy = (y_points[center] >= y_points[j]) ? y_points[center] - y_points[j]
                                                   : y_points[j] - y_points[center];
            if (dx <= radius && dy <= radius && dx * dx + dy * dy <= radius * radius) begin
               hits[j] = 1'b1;
               final_hit = j;
            end
         end
      end
      if (final_hit < 0) begin
         entry.neighbor_index = '0;
         entry.found = 1'b0;
         entry.last = 1'b1;
         neighbor_queue.push_back(entry);
      end else begin
         for (int j = 0; j < span; j++) begin
            if (hits[j]) begin
               entry.neighbor_index = j[INDEX_WIDTH-1:0];
               entry.found = 1'b1;
               entry.last = (j == final_hit);
               neighbor_queue.push_back(entry);
            end
         end
      end
   endfunction

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         point_count = COUNT_WIDTH'(RESET_POINT_COUNT);
         cutoff_dist = CUTOFF_WIDTH'(RESET_CUTOFF);
         neighbor_queue.delete();
         results_checked = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got.neighbor_index = rsp_neighbor_index;
            got.found = rsp_found;
            got.last = rsp_last;
            results_checked++;
            if (neighbor_queue.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: expected none, got index %0d found %0d last %0d",
                        $time, got.neighbor_index, got.found, got.last);
            end else begin
               want = neighbor_queue.pop_front();
               if (got !== want) begin
                  mismatch_count++;
                  $display({"%0t: result mismatch: expected index %0d found %0d last %0d, ",
                            "got index %0d found %0d last %0d"}, $time, want.neighbor_index,
                           want.found, want.last, got.neighbor_index, got.found, got.last);
               end
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               CSR_POINT_COUNT: begin
                  point_count = csr_write_data[COUNT_WIDTH-1:0];
               end
               CSR_CUTOFF_DIST: begin
                  cutoff_dist = csr_write_data[CUTOFF_WIDTH-1:0];
               end
               default: begin
               end
            endcase
         end
         if (req_push && !req_full) begin
            if (req_mode == MODE_QUERY) begin
               find_neighbors(req_point_index);
            end else begin
               x_points[req_point_index] = req_x_coord;
               y_points[req_point_index] = req_y_coord;
            end
         end
      end
      outstanding = neighbor_queue.size();
   end

endmodule

FILE: tb/fixed_radius_neighbor_list_tb.sv
// Testbench top for the fixed-radius neighbor list: drives loads, queries and register
// writes with random pacing and gives the verdict from the checker's mismatch count.
// Depends on frnl_pkg, frnl_neighbor_checker and the block fixed_radius_neighbor_list.
`timescale 1ns / 1ps

module fixed_radius_neighbor_list_tb;
   import frnl_pkg::*;

   localparam int STORE_DEPTH  = MAX_POINTS_DEFAULT;
   localparam int COORD_BITS   = COORD_WIDTH_DEFAULT;
   localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1000000;

   logic                       clock;
   logic                       reset;
   logic                       req_push;
   logic                       req_full;
   logic                       req_mode;
   logic [INDEX_WIDTH-1:0]     req_point_index;
   logic [COORD_BITS-1:0]      req_x_coord;
   logic [COORD_BITS-1:0]      req_y_coord;
   logic                       rsp_empty;
   logic                       rsp_pop;
   logic [INDEX_WIDTH-1:0]     rsp_neighbor_index;
   logic                       rsp_found;
   logic                       rsp_last;
   logic                       csr_write_enable;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [CSR_DATA_WIDTH-1:0]  csr_write_data;

   int mismatch_count;
   int outstanding;
   int results_checked;
   int cycles;
   int gap_max;
   int stall_max;
   int load_count;
   int query_count;
   int setting_count;
   int x_center;
   int y_center;
   bit loaded [STORE_DEPTH];

   fixed_radius_neighbor_list uut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_point_index    (req_point_index),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_found          (rsp_found),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   frnl_neighbor_checker neighbor_check (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_full           (req_full),
      .req_mode           (req_mode),
      .req_point_index    (req_point_index),
      .req_x_coord        (req_x_coord),
      .req_y_coord        (req_y_coord),
      .rsp_empty          (rsp_empty),
      .rsp_pop            (rsp_pop),
      .rsp_neighbor_index (rsp_neighbor_index),
      .rsp_found          (rsp_found),
      .rsp_last           (rsp_last),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatch_count),
      .outstanding        (outstanding),
      .results_checked    (results_checked)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
   end

   initial begin
      wait (cycles >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      int stall;
      rsp_pop = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = $urandom_range(0, stall_max);
         if (stall > 0) begin
            rsp_pop <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         @(negedge clock);
      end
   end

   function automatic int pick_pace();
      case ($urandom_range(0, 2))
         0: return 0;
         1: return 12;
         default: return $urandom_range(1, 12);
      endcase
   endfunction

   function automatic int near(input int center, input int spread);
      int value;
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, COORD_MAX);
      value = center - spread / 2 + int'($urandom_range(0, spread));
      if (value < 0) value = 0;
      if (value > COORD_MAX) value = COORD_MAX;
      return value;
   endfunction

   task automatic send_item(input mode_type mode, input int index, input int x, input int y);
      int pause;
      pause = $urandom_range(0, gap_max);
      if (pause > 0) begin
         req_push <= 1'b0;
         repeat (pause) @(negedge clock);
      end
      req_mode <= mode;
      req_point_index <= INDEX_WIDTH'(index);
      req_x_coord <= COORD_BITS'(x);
      req_y_coord <= COORD_BITS'(y);
      req_push <= 1'b1;
      do @(posedge clock); while (req_full);
      @(negedge clock);
      if (mode == MODE_LOAD) begin
         loaded[index] = 1'b1;
         load_count++;
      end else begin
         query_count++;
      end
   endtask

   task automatic settle();
      req_push <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type which, input int value);
      csr_write_enable <= 1'b1;
      csr_index <= which;
      csr_write_data <= CSR_DATA_WIDTH'(value);
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input int count, input int cutoff);
      settle();
      write_reg(CSR_POINT_COUNT, count);
      write_reg(CSR_CUTOFF_DIST, cutoff);
      setting_count++;
   endtask

   task automatic run_phase(input int count, input int cutoff, input int item_total);
      int span;
      int spread;
      int index;
      configure(count, cutoff);
      gap_max = pick_pace();
      stall_max = pick_pace();
      spread = cutoff * 3;
      if (spread < 4) spread = 4;
      if (spread > COORD_MAX) spread = COORD_MAX;
      span = (count > STORE_DEPTH) ? STORE_DEPTH : count;
      for (int j = 0; j < span; j++) begin
         if (!loaded[j]) begin
            send_item(MODE_LOAD, j, near(x_center, spread), near(y_center, spread));
         end
      end
      repeat (item_total) begin
         if ($urandom_range(0, 2) == 0) begin
            send_item(MODE_LOAD, $urandom_range(0, STORE_DEPTH - 1),
                      near(x_center, spread), near(y_center, spread));
         end else begin
            do index = $urandom_range(0, STORE_DEPTH - 1); while (!loaded[index]);
            send_item(MODE_QUERY, index, $urandom_range(0, COORD_MAX),
                      $urandom_range(0, COORD_MAX));
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      req_push = 1'b0;
      req_mode = MODE_LOAD;
      req_point_index = '0;
      req_x_coord = '0;
      req_y_coord = '0;
      csr_write_enable = 1'b0;
      csr_index = CSR_POINT_COUNT;
      csr_write_data = '0;
      gap_max = 0;
      stall_max = 3;
      x_center = $urandom_range(4096, COORD_MAX - 4096);
      y_center = $urandom_range(4096, COORD_MAX - 4096);
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Four active points with a cutoff of 5.0; point 2 sits exactly on the cutoff.
      configure(4, 'h0500);
      send_item(MODE_LOAD, 0, 'h0000, 'h0000);
      send_item(MODE_LOAD, 1, COORD_MAX, COORD_MAX);
      send_item(MODE_LOAD, 2, 'h0300, 'h0400);
      send_item(MODE_LOAD, 3, 'h0300, 'h0401);
      send_item(MODE_LOAD, 10, 'h0100, 'h0000);
      send_item(MODE_LOAD, STORE_DEPTH - 1, 'h0000, 'h0500);
      send_item(MODE_QUERY, 0, 0, 0);
      send_item(MODE_QUERY, 1, 0, 0);
      send_item(MODE_QUERY, 10, 0, 0);
      send_item(MODE_QUERY, STORE_DEPTH - 1, COORD_MAX, COORD_MAX);

      // A zero cutoff still matches a coincident point.
      configure(4, 0);
      send_item(MODE_LOAD, 3, 'h0000, 'h0000);
      send_item(MODE_QUERY, 0, 0, 0);
      send_item(MODE_QUERY, 2, 0, 0);

      // At the widest cutoff each axis passes alone but the sum of squares can still fail.
      configure(4, COORD_MAX);
      send_item(MODE_QUERY, 0, 0, 0);
      send_item(MODE_QUERY, 1, 0, 0);

      configure(0, 'h0500);
      send_item(MODE_QUERY, 0, 0, 0);

      run_phase(64, 6400, 10);
      run_phase(127, $urandom_range(256, 4096), 10);
      run_phase(1, COORD_MAX, 8);
      run_phase(0, $urandom_range(0, COORD_MAX), 6);
      run_phase($urandom_range(2, 63), 0, 10);
      run_phase($urandom_range(2, 64), $urandom_range(0, COORD_MAX), 10);
      run_phase(64, $urandom_range(1, 512), 12);
      run_phase($urandom_range(65, 127), COORD_MAX, 8);
      run_phase($urandom_range(1, 64), $urandom_range(0, 8192), 10);

      settle();
      $display("Sent %0d point loads and %0d neighbor queries across %0d register settings.",
               load_count, query_count, setting_count);
      $display("Checked %0d neighbor results, %0d of them mismatched.",
               results_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

FILE: fixed_radius_neighbor_list.f
hdl/frnl_pkg.sv
hdl/frnl_fifo.sv
hdl/frnl_ram.sv
hdl/frnl_front.sv
hdl/frnl_back.sv
hdl/fixed_radius_neighbor_list.sv
tb/frnl_neighbor_checker.sv
tb/fixed_radius_neighbor_list_tb.sv
